FILE: rtl/mjt_pkg.sv
// shared types and constants for the min-jerk trajectory core
package mjt_pkg;

  localparam int unsigned ArmSlotsDefault  = 16;
  localparam int unsigned HandSlotsDefault = 16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ARM  = 2'd1,
    OP_HAND = 2'd2,
    OP_TICK = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_SAMPLE  = 3'd0,
    ST_OK      = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_ENDED   = 3'd4
  } status_e;

  // one item as it travels from the front to the back
  typedef struct packed {
    op_e                op;
    logic [15:0]        tm;
    logic signed [15:0] z;
    logic signed [15:0] x;
    logic signed [15:0] p;
    logic [2:0]         hb;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] z;
    logic signed [15:0] x;
    logic signed [15:0] p;
    logic [2:0]         hand;
    logic [15:0]        idx;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ARM_RD,
    BK_ARM_CHK,
    BK_SEG,
    BK_DIV,
    BK_POW,
    BK_BLEND,
    BK_AXIS,
    BK_HAND_RD,
    BK_HAND_CHK,
    BK_DONE
  } bk_state_e;

endpackage

FILE: rtl/mjt_front.sv
// input stage: two-entry item queue between the ports and the sequencer
module mjt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  mjt_pkg::item_t item_i,
  output logic          valid_o,
  input  logic          take_i,
  output mjt_pkg::item_t item_o
);
  import mjt_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = take_i && valid_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count not advanced on push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue count not reduced on take");
endmodule

FILE: rtl/mjt_div.sv
// restoring divider: q = floor(num*2^16/den) for num < den, one bit per cycle
module mjt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  logic [16:0] rem_q;
  logic [15:0] quo_q, den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [17:0] trial;

  assign trial  = {rem_q, 1'b0} - {2'b0, den_q};
  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == 5'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 5'd0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 5'd16;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 5'd1;
    end
  end

  // num < den is guaranteed by the caller, so the quotient fits 16 bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q && cnt_q != 5'd0) begin
      if (!trial[17]) begin
        rem_q <= trial[16:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[15:0], 1'b0};
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/mjt_back.sv
// sequencer: schedule tables, sampling, single-entry result register
module mjt_back #(
  parameter int unsigned ARM_SLOTS  = mjt_pkg::ArmSlotsDefault,
  parameter int unsigned HAND_SLOTS = mjt_pkg::HandSlotsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mjt_pkg::item_t  item_i,
  output logic            take_o,
  output logic            res_valid_o,
  input  logic            res_pop_i,
  output mjt_pkg::result_t res_o
);
  import mjt_pkg::*;

  localparam int unsigned AW = (ARM_SLOTS > 1) ? $clog2(ARM_SLOTS) : 1;
  localparam int unsigned HW = (HAND_SLOTS > 1) ? $clog2(HAND_SLOTS) : 1;
  localparam int unsigned AC = $clog2(ARM_SLOTS + 1);
  localparam int unsigned HC = $clog2(HAND_SLOTS + 1);

  logic [63:0] arm_mem [ARM_SLOTS];
  logic [18:0] hand_mem [HAND_SLOTS];
  logic [63:0] arm_rd_q;
  logic [18:0] hand_rd_q;

  bk_state_e state_q, state_d;
  logic [AC-1:0] arm_cnt_q, arm_next_q;
  logic [HC-1:0] hand_cnt_q, hand_next_q;
  logic [15:0]   seg_t_q, last_arm_q, last_hand_q;
  logic signed [15:0] seg_p_q [3];
  logic [2:0]    hand_now_q;
  logic [16:0]   tick_q;
  logic          bad_q;
  logic          res_v_q;
  result_t       res_q;
  logic [15:0]   t_q, num_q, den_q;
  logic [15:0]   pw_q [4];
  logic [1:0]    pw_i_q, ax_q;
  logic signed [15:0] now_q [3];
  logic [15:0]   blend_q;
  logic          div_start, div_done;
  logic [15:0]   div_quo;

  logic [15:0] finish;
  logic [16:0] cur;
  logic arm_more, hand_more;
  status_e take_st;
  logic [1:0]  pw_src;
  logic [31:0] pw_prod;
  logic signed [19:0] bl_sum;
  logic signed [16:0] ax_d;
  logic signed [34:0] ax_prod;
  logic signed [15:0] fin_ax, st_ax;

  assign finish    = (last_arm_q > last_hand_q) ? last_arm_q : last_hand_q;
  assign cur       = tick_q;
  assign arm_more  = arm_next_q < arm_cnt_q;
  assign hand_more = hand_next_q < hand_cnt_q;
  assign take_o    = (state_q == BK_IDLE) && valid_i && !res_v_q;
  assign res_valid_o = res_v_q;
  assign res_o     = res_q;

  // status of the transaction at the head of the queue
  always_comb begin
    take_st = ST_SAMPLE;
    case (item_i.op)
      OP_LOAD: take_st = ST_OK;
      OP_ARM: begin
        if (bad_q) take_st = ST_INVALID;
        else if (arm_cnt_q >= AC'(ARM_SLOTS)) take_st = ST_FULL;
        else if (item_i.tm <= last_arm_q) take_st = ST_INVALID;
        else take_st = ST_OK;
      end
      OP_HAND: begin
        if (bad_q) take_st = ST_INVALID;
        else if (hand_cnt_q >= HC'(HAND_SLOTS)) take_st = ST_FULL;
        else if (hand_cnt_q != '0 && item_i.tm <= last_hand_q) take_st = ST_INVALID;
        else take_st = ST_OK;
      end
      default: begin
        if (bad_q) take_st = ST_INVALID;
        else if (cur > 17'(finish)) take_st = ST_ENDED;
        else take_st = ST_SAMPLE;
      end
    endcase
  end

  // pass 0 squares t, later passes multiply the previous power by t
  assign pw_src  = (pw_i_q == 2'd0) ? 2'd0 : pw_i_q - 2'd1;
  assign pw_prod = pw_q[pw_src] * t_q;
  assign bl_sum  = 20'sd10 * $signed({4'b0, pw_q[1]}) - 20'sd15 * $signed({4'b0, pw_q[2]})
                 + 20'sd6 * $signed({4'b0, pw_q[3]});

  always_comb begin
    case (ax_q)
      2'd0:    begin fin_ax = arm_rd_q[47:32]; st_ax = seg_p_q[0]; end
      2'd1:    begin fin_ax = arm_rd_q[31:16]; st_ax = seg_p_q[1]; end
      default: begin fin_ax = arm_rd_q[15:0];  st_ax = seg_p_q[2]; end
    endcase
  end
  assign ax_d    = 17'(fin_ax) - 17'(st_ax);
  assign ax_prod = ax_d * $signed({1'b0, blend_q});

  mjt_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(den_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      BK_IDLE: if (take_o) begin
        if (item_i.op == OP_TICK && take_st == ST_SAMPLE) state_d = BK_ARM_RD;
        else state_d = BK_DONE;
      end
      BK_ARM_RD:   state_d = BK_ARM_CHK;
      BK_ARM_CHK:  if (arm_more && cur >= 17'(arm_rd_q[63:48])) state_d = BK_ARM_RD;
                   else state_d = BK_SEG;
      BK_SEG: begin
        if (!arm_more) state_d = BK_HAND_RD;
        else if (den_q == 16'd0 || num_q >= den_q) state_d = BK_HAND_RD;
        else begin
          div_start = 1'b1;
          state_d   = BK_DIV;
        end
      end
      BK_DIV:      if (div_done) state_d = BK_POW;
      BK_POW:      if (pw_i_q == 2'd3) state_d = BK_BLEND;
      BK_BLEND:    state_d = BK_AXIS;
      BK_AXIS:     if (ax_q == 2'd2) state_d = BK_HAND_RD;
      BK_HAND_RD:  state_d = BK_HAND_CHK;
      BK_HAND_CHK: if (!(hand_more && cur >= 17'(hand_rd_q[18:3]))) state_d = BK_DONE;
                   else state_d = BK_HAND_RD;
      BK_DONE:     state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  // table reads, registered
  always_ff @(posedge clk_i) begin
    if (state_q == BK_ARM_RD || state_q == BK_IDLE) arm_rd_q <= arm_mem[arm_next_q[AW-1:0]];
    if (state_q == BK_HAND_RD) hand_rd_q <= hand_mem[hand_next_q[HW-1:0]];
    if (state_q == BK_IDLE && take_o && take_st == ST_OK) begin
      if (item_i.op == OP_ARM)
        arm_mem[arm_cnt_q[AW-1:0]] <= {item_i.tm, item_i.z, item_i.x, item_i.p};
      if (item_i.op == OP_HAND)
        hand_mem[hand_cnt_q[HW-1:0]] <= {item_i.tm, item_i.hb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      arm_cnt_q <= '0; arm_next_q <= '0; hand_cnt_q <= '0; hand_next_q <= '0;
      seg_t_q <= '0; last_arm_q <= '0; last_hand_q <= '0;
      seg_p_q[0] <= '0; seg_p_q[1] <= '0; seg_p_q[2] <= '0;
      hand_now_q <= '0; tick_q <= '0; bad_q <= 1'b0; res_v_q <= 1'b0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_DONE) res_v_q <= 1'b1;
      else if (res_pop_i && res_v_q) res_v_q <= 1'b0;
      case (state_q)
        BK_IDLE: if (take_o) begin
          res_q <= '{status: take_st, z: '0, x: '0, p: '0, hand: '0, idx: '0,
                     last: 1'b0};
          case (item_i.op)
            OP_LOAD: begin
              arm_cnt_q <= '0; arm_next_q <= '0; hand_cnt_q <= '0; hand_next_q <= '0;
              seg_t_q <= '0; last_arm_q <= '0; last_hand_q <= '0; tick_q <= '0;
              bad_q <= 1'b0;
              seg_p_q[0] <= item_i.z; seg_p_q[1] <= item_i.x; seg_p_q[2] <= item_i.p;
              hand_now_q <= item_i.hb;
            end
            OP_ARM: begin
              if (take_st == ST_OK) begin
                arm_cnt_q <= arm_cnt_q + 1'b1; last_arm_q <= item_i.tm;
              end else if (take_st == ST_INVALID) bad_q <= 1'b1;
            end
            OP_HAND: begin
              if (take_st == ST_OK) begin
                hand_cnt_q <= hand_cnt_q + 1'b1; last_hand_q <= item_i.tm;
              end else if (take_st == ST_INVALID) bad_q <= 1'b1;
            end
            default: ;
          endcase
        end
        BK_ARM_RD: ;
        BK_ARM_CHK: begin
          if (arm_more && cur >= 17'(arm_rd_q[63:48])) begin
            seg_t_q <= arm_rd_q[63:48];
            seg_p_q[0] <= arm_rd_q[47:32]; seg_p_q[1] <= arm_rd_q[31:16];
            seg_p_q[2] <= arm_rd_q[15:0];
            arm_next_q <= arm_next_q + 1'b1;
          end else begin
            num_q <= (cur >= 17'(seg_t_q)) ? 16'(cur - 17'(seg_t_q)) : 16'd0;
            den_q <= (arm_rd_q[63:48] > seg_t_q) ? arm_rd_q[63:48] - seg_t_q : 16'd0;
          end
        end
        BK_SEG: begin
          if (!arm_more) begin
            now_q[0] <= seg_p_q[0]; now_q[1] <= seg_p_q[1]; now_q[2] <= seg_p_q[2];
          end else if (den_q == 16'd0 || num_q >= den_q) begin
            now_q[0] <= arm_rd_q[47:32]; now_q[1] <= arm_rd_q[31:16];
            now_q[2] <= arm_rd_q[15:0];
          end
        end
        BK_DIV: if (div_done) begin
          t_q <= div_quo; pw_q[0] <= div_quo; pw_i_q <= 2'd0;
        end
        BK_POW: begin
          // pw_q[k] holds t^(k+2) after this pass
          pw_q[pw_i_q] <= pw_prod[31:16];
          pw_i_q <= pw_i_q + 2'd1;
        end
        BK_BLEND: begin
          blend_q <= bl_sum < 0 ? 16'd0 : (bl_sum > 20'sd65535 ? 16'd65535 : 16'(bl_sum));
          ax_q <= 2'd0;
        end
        BK_AXIS: begin
          now_q[ax_q] <= st_ax + 16'(ax_prod >>> 16);
          ax_q <= ax_q + 2'd1;
        end
        BK_HAND_RD: ;
        BK_HAND_CHK: begin
          if (hand_more && cur >= 17'(hand_rd_q[18:3])) begin
            hand_now_q <= hand_rd_q[2:0];
            hand_next_q <= hand_next_q + 1'b1;
          end
        end
        BK_DONE: begin
          // only a tick that samples carries the sample status here
          if (res_q.status == ST_SAMPLE) begin
            res_q <= '{status: ST_SAMPLE, z: now_q[0], x: now_q[1], p: now_q[2],
                       hand: hand_now_q, idx: cur[15:0], last: (cur == 17'(finish))};
            tick_q <= cur + 17'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) arm_next_q <= arm_cnt_q)
    else $error("arm cursor past count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) hand_next_q <= hand_cnt_q)
    else $error("hand cursor past count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) take_o |-> !res_v_q)
    else $error("item taken over pending result");
endmodule

FILE: rtl/min_jerk_waypoint_trajectory_core.sv
// top level of the min-jerk waypoint trajectory core
// loads, appends and ended or invalid ticks skip the sampling path; a sampling tick past
// the last arm waypoint skips the divider, else it runs the divider, four power steps and
// three axis products, and each arm or gripper waypoint passed adds a table read and check
// throughput: one transaction at a time; the next starts the cycle after a result is popped
// reset: rst_ni async low clears counts, cursors, pose, tick counter and queues
module min_jerk_waypoint_trajectory_core #(
  parameter int unsigned ARM_SLOTS  = mjt_pkg::ArmSlotsDefault,
  parameter int unsigned HAND_SLOTS = mjt_pkg::HandSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] time_tick_i,
  input  logic signed [15:0] z_value_i,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] pitch_value_i,
  input  logic [2:0]  hand_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic signed [15:0] out_z_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_pitch_o,
  output logic [2:0]  out_hand_o,
  output logic [15:0] sample_index_o,
  output logic        last_o
);
  import mjt_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_take, res_valid;

  // pack the input transaction
  assign in_item = '{op: op_e'(opcode_i), tm: time_tick_i, z: z_value_i,
                     x: x_value_i, p: pitch_value_i, hb: hand_bits_i};

  // front queue decouples the pusher from the sequencer
  mjt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  // sequencer holds its result register until popped
  mjt_back #(.ARM_SLOTS(ARM_SLOTS), .HAND_SLOTS(HAND_SLOTS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .take_o(q_take),
    .res_valid_o(res_valid), .res_pop_i(pop), .res_o(res)
  );

  assign empty          = !res_valid;
  assign status_o       = res.status;
  assign out_z_o        = res.z;
  assign out_x_o        = res.x;
  assign out_pitch_o    = res.p;
  assign out_hand_o     = res.hand;
  assign sample_index_o = res.idx;
  assign last_o         = res.last;
endmodule

FILE: dv/tb.sv
// self-checking testbench for the min-jerk waypoint trajectory core
`timescale 1ns / 100ps

module tb;
  import mjt_pkg::*;

  localparam int NumItems  = 1350;
  localparam int CalmAfter = 1200;
  localparam int Slots     = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] opcode_i = '0;
  logic [15:0] time_tick_i = '0;
  logic signed [15:0] z_value_i = '0, x_value_i = '0, pitch_value_i = '0;
  logic [2:0] hand_bits_i = '0;
  logic [2:0] status_o;
  logic signed [15:0] out_z_o, out_x_o, out_pitch_o;
  logic [2:0] out_hand_o;
  logic [15:0] sample_index_o;
  logic last_o;

  min_jerk_waypoint_trajectory_core u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shadow of the trajectory state
  logic [15:0]        arm_tm   [Slots];
  logic signed [15:0] arm_pose [Slots][3];
  logic [15:0]        hand_tm  [Slots];
  logic [2:0]         hand_val [Slots];
  int unsigned arm_cnt, hand_cnt, arm_nxt, hand_nxt;
  int unsigned seg_tm, tick_cnt, last_arm, last_hand;
  logic signed [15:0] seg_pose [3];
  logic [2:0] hand_cur;
  bit sched_bad;

  result_t awaited_q[$];
  int sent;
  int errors = 0;
  bit calm;

  task automatic clear_shadow();
    arm_cnt = 0; hand_cnt = 0; arm_nxt = 0; hand_nxt = 0;
    seg_tm = 0; tick_cnt = 0; last_arm = 0; last_hand = 0;
    hand_cur = '0; sched_bad = 0;
    for (int k = 0; k < 3; k++) seg_pose[k] = '0;
  endtask

  // one transaction through the trajectory math
  task automatic trajectory_step(input item_t it, output result_t r);
    int unsigned finish, cur, num, den;
    longint t, t2, t3, t4, t5, b, d;
    logic signed [15:0] now [3];
    r = '0;
    case (it.op)
      OP_LOAD: begin
        clear_shadow();
        seg_pose[0] = it.z; seg_pose[1] = it.x; seg_pose[2] = it.p;
        hand_cur = it.hb;
        r.status = ST_OK;
      end
      OP_ARM: begin
        if (sched_bad) r.status = ST_INVALID;
        else if (arm_cnt >= Slots) r.status = ST_FULL;
        else if (it.tm <= last_arm) begin
          sched_bad = 1; r.status = ST_INVALID;
        end else begin
          arm_tm[arm_cnt] = it.tm;
          arm_pose[arm_cnt][0] = it.z; arm_pose[arm_cnt][1] = it.x;
          arm_pose[arm_cnt][2] = it.p;
          arm_cnt++; last_arm = it.tm; r.status = ST_OK;
        end
      end
      OP_HAND: begin
        if (sched_bad) r.status = ST_INVALID;
        else if (hand_cnt >= Slots) r.status = ST_FULL;
        else if (hand_cnt > 0 && it.tm <= last_hand) begin
          sched_bad = 1; r.status = ST_INVALID;
        end else begin
          hand_tm[hand_cnt] = it.tm; hand_val[hand_cnt] = it.hb;
          hand_cnt++; last_hand = it.tm; r.status = ST_OK;
        end
      end
      default: begin
        finish = (last_arm > last_hand) ? last_arm : last_hand;
        cur = tick_cnt;
        if (sched_bad) r.status = ST_INVALID;
        else if (cur > finish) r.status = ST_ENDED;
        else begin
          // catch up on every waypoint already reached, late appends too
          while (arm_nxt < arm_cnt && cur >= arm_tm[arm_nxt]) begin
            seg_tm = arm_tm[arm_nxt];
            for (int k = 0; k < 3; k++) seg_pose[k] = arm_pose[arm_nxt][k];
            arm_nxt++;
          end
          for (int k = 0; k < 3; k++) now[k] = seg_pose[k];
          if (arm_nxt < arm_cnt) begin
            num = (cur >= seg_tm) ? cur - seg_tm : 0;
            den = (arm_tm[arm_nxt] > seg_tm) ? arm_tm[arm_nxt] - seg_tm : 0;
            if (den == 0 || num >= den) begin
              for (int k = 0; k < 3; k++) now[k] = arm_pose[arm_nxt][k];
            end else begin
              t = (longint'(num) << 16) / den;
              if (t > 65535) t = 65535;
              t2 = (t * t) >> 16;
              t3 = (t2 * t) >> 16;
              t4 = (t3 * t) >> 16;
              t5 = (t4 * t) >> 16;
              b = 10 * t3 - 15 * t4 + 6 * t5;
              if (b < 0) b = 0;
              if (b > 65535) b = 65535;
              for (int k = 0; k < 3; k++) begin
                d = longint'(arm_pose[arm_nxt][k]) - longint'(seg_pose[k]);
                // arithmetic shift floors toward minus infinity
                now[k] = 16'(longint'(seg_pose[k]) + ((d * b) >>> 16));
              end
            end
          end
          while (hand_nxt < hand_cnt && cur >= hand_tm[hand_nxt]) begin
            hand_cur = hand_val[hand_nxt];
            hand_nxt++;
          end
          r.status = ST_SAMPLE;
          r.z = now[0]; r.x = now[1]; r.p = now[2];
          r.hand = hand_cur; r.idx = 16'(cur); r.last = (cur == finish);
          tick_cnt = cur + 1;
        end
      end
    endcase
  endtask

  // drive one transaction from a falling edge, predict it once it is taken
  task automatic send(input item_t it, input bit typed = 0, input result_t want = '0);
    result_t r;
    push = 1'b1;
    opcode_i = it.op; time_tick_i = it.tm; z_value_i = it.z;
    x_value_i = it.x; pitch_value_i = it.p; hand_bits_i = it.hb;
    do @(posedge clk_i); while (full);
    trajectory_step(it, r);
    awaited_q.insert(awaited_q.size(), typed ? want : r);
    sent++;
    @(negedge clk_i);
    push = 1'b0;
    if (!calm && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
  endtask

  function automatic item_t mk(op_e op, int tm, int z = 0, int x = 0, int p = 0, int hb = 0);
    mk.op = op; mk.tm = 16'(tm); mk.z = 16'(z); mk.x = 16'(x);
    mk.p = 16'(p); mk.hb = 3'(hb);
  endfunction

  function automatic result_t rs(status_e st, int z = 0, int x = 0, int p = 0,
                                 int h = 0, int idx = 0, int lst = 0);
    rs.status = st; rs.z = 16'(z); rs.x = 16'(x); rs.p = 16'(p);
    rs.hand = 3'(h); rs.idx = 16'(idx); rs.last = 1'(lst);
  endfunction

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  row_t directed[$];

  // result side: random stall bursts, none once the run calms down
  int stall = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      pop <= rst_ni;
    end else if (stall > 0) begin
      stall--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall = $urandom_range(0, 16);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // compare every accepted result with the oldest waiting prediction
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && pop && !empty) begin
      if (awaited_q.size() == 0) begin
        $error("unexpected result transaction, status %0d", status_o);
        errors++;
      end else begin
        w = awaited_q.pop_front();
        if (status_o !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, status_o); errors++;
        end
        if (out_z_o !== w.z) begin
          $error("out_z: expected %0d actual %0d", w.z, out_z_o); errors++;
        end
        if (out_x_o !== w.x) begin
          $error("out_x: expected %0d actual %0d", w.x, out_x_o); errors++;
        end
        if (out_pitch_o !== w.p) begin
          $error("out_pitch: expected %0d actual %0d", w.p, out_pitch_o); errors++;
        end
        if (out_hand_o !== w.hand) begin
          $error("out_hand: expected %0d actual %0d", w.hand, out_hand_o); errors++;
        end
        if (sample_index_o !== w.idx) begin
          $error("sample_index: expected %0d actual %0d", w.idx, sample_index_o); errors++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0d actual %0d", w.last, last_o); errors++;
        end
      end
    end
  end

  // one load, a random schedule, then ticks through the stream
  task automatic run_schedule();
    int na, nh, at, ht, n_tick, fin;
    bit first_hand;
    send(mk(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom));
    if ($urandom_range(0, 14) == 0) begin
      // overflow the arm table
      for (int i = 1; i <= Slots + 2; i++)
        send(mk(OP_ARM, i, $urandom, $urandom, $urandom));
    end
    na = $urandom_range(0, 5);
    nh = $urandom_range(0, 4);
    at = 0; ht = 0; first_hand = 1;
    while (na + nh > 0) begin
      if (na > 0 && (nh == 0 || $urandom_range(0, 1))) begin
        if ($urandom_range(0, 19) == 0) at += $urandom_range(1, 65535 - at);
        else if ($urandom_range(0, 14) != 0) at += $urandom_range(1, 6);
        // otherwise a repeated time breaks the order
        send(mk(OP_ARM, at, $urandom, $urandom, $urandom, $urandom));
        na--;
      end else begin
        if (!first_hand || $urandom_range(0, 1)) begin
          if ($urandom_range(0, 14) != 0) ht += $urandom_range(1, 6);
        end
        first_hand = 0;
        send(mk(OP_HAND, ht, $urandom, $urandom, $urandom, $urandom));
        nh--;
      end
    end
    fin = (at > ht) ? at : ht;
    n_tick = (fin > 30) ? 30 : fin + $urandom_range(1, 3);
    for (int i = 0; i < n_tick; i++) begin
      if ($urandom_range(0, 24) == 0)
        send(mk(OP_ARM, at + $urandom_range(0, 3), $urandom, $urandom, $urandom));
      if ($urandom_range(0, 9) == 0)
        send(mk(op_e'($urandom_range(0, 3)), $urandom_range(0, 20),
                $urandom, $urandom, $urandom, $urandom));
      else
        send(mk(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    sent = 0; calm = 0;
    clear_shadow();
    // extremes and each special case, expectations typed where obvious
    directed = '{
      '{mk(OP_LOAD, 0, 'h7fff, 'h8000, 0, 7), 1, rs(ST_OK)},
      '{mk(OP_TICK, 'hffff), 1, rs(ST_SAMPLE, 'h7fff, 'h8000, 0, 7, 0, 1)},
      '{mk(OP_TICK, 0), 1, rs(ST_ENDED)},
      '{mk(OP_ARM, 0, 1, 1, 1), 1, rs(ST_INVALID)},
      '{mk(OP_HAND, 5, 0, 0, 0, 3), 1, rs(ST_INVALID)},
      '{mk(OP_TICK, 0), 1, rs(ST_INVALID)},
      '{mk(OP_LOAD, 0, 'h8000, 'h7fff, 'h7fff, 0), 1, rs(ST_OK)},
      '{mk(OP_HAND, 0, 0, 0, 0, 5), 1, rs(ST_OK)},
      '{mk(OP_ARM, 4, 'h7fff, 'h8000, 'h8000), 1, rs(ST_OK)},
      '{mk(OP_HAND, 0, 0, 0, 0, 2), 1, rs(ST_INVALID)},
      '{mk(OP_LOAD, 0, 0, 0, 0, 0), 1, rs(ST_OK)},
      '{mk(OP_ARM, 3, 'h1000, -'h1000, 'h7fff), 1, rs(ST_OK)},
      '{mk(OP_HAND, 2, 0, 0, 0, 6), 1, rs(ST_OK)},
      '{mk(OP_TICK, 0), 0, '0},
      '{mk(OP_TICK, 0), 0, '0},
      '{mk(OP_TICK, 0), 0, '0},
      '{mk(OP_ARM, 2, 5, 5, 5), 1, rs(ST_INVALID)},
      '{mk(OP_LOAD, 0, 'h7fff, 'h7fff, 'h8000, 1), 1, rs(ST_OK)},
      '{mk(OP_ARM, 'hffff, 'h8000, 'h8000, 'h7fff), 1, rs(ST_OK)},
      '{mk(OP_TICK, 0), 0, '0},
      '{mk(OP_TICK, 0), 0, '0},
      '{mk(OP_ARM, 'hffff, 0, 0, 0), 1, rs(ST_INVALID)}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send(directed[i].it, directed[i].typed, directed[i].want);
    while (sent < NumItems) begin
      calm = (sent > CalmAfter);
      if (sent > 600 && sent < 700) begin
        // hold the sender until the core has drained
        while (awaited_q.size() != 0) @(negedge clk_i);
      end
      run_schedule();
    end
    while (awaited_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
